[src/nass_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// nass_pkg
// Shared types and constants for the nearest available site selector.
// ============================================================================
package nass_pkg;

    localparam int POS_W      = 12;
    localparam int DIM_W      = 13;
    localparam int SITE_W     = 4;
    localparam int SITE_IDX_W = 6;
    localparam int SQ_W       = 2 * POS_W;
    localparam int DIST_W     = SQ_W + 1;
    localparam int GRID_DIM_MAX = 4096;
    localparam logic [DIM_W-1:0] GRID_RESET = 13'd4096;

    typedef enum logic [1:0] {
        KIND_PLACE   = 2'd0,
        KIND_AVAIL   = 2'd1,
        KIND_TIMEOUT = 2'd2,
        KIND_QUERY   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    typedef enum logic {
        REG_GRID_WIDTH  = 1'b0,
        REG_GRID_HEIGHT = 1'b1
    } t_reg;

    typedef struct packed {
        logic place;
        logic mark_on;
        logic mark_off;
    } t_cell_cmd;

    typedef struct packed {
        logic                  found;
        logic [DIST_W-1:0]     dsq;
        logic [SITE_IDX_W-1:0] idx;
    } t_tok;

endpackage
`default_nettype wire

[src/nass_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// nass_cell
// One site slot: holds position and marks, computes the squared distance to
// the current query cell and updates the running best that passes through.
// ============================================================================
module nass_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  nass_pkg::t_cell_cmd         i_cmd,
    input  logic [nass_pkg::POS_W-1:0]  i_pos_x,
    input  logic [nass_pkg::POS_W-1:0]  i_pos_y,
    input  logic [nass_pkg::POS_W-1:0]  i_qry_x,
    input  logic [nass_pkg::POS_W-1:0]  i_qry_y,
    input  nass_pkg::t_tok              i_tok,
    output nass_pkg::t_tok              o_tok
);
    import nass_pkg::*;

    logic [POS_W-1:0]  r_col;
    logic [POS_W-1:0]  r_row;
    logic              r_placed;
    logic              r_ready;
    logic [SQ_W-1:0]   r_sq_x;
    logic [SQ_W-1:0]   r_sq_y;
    logic [DIST_W-1:0] r_dist;
    t_tok              r_tok;

    logic [POS_W-1:0]  w_dx;
    logic [POS_W-1:0]  w_dy;
    logic              w_take;

    assign w_dx = (r_col >= i_qry_x) ? (r_col - i_qry_x) : (i_qry_x - r_col);
    assign w_dy = (r_row >= i_qry_y) ? (r_row - i_qry_y) : (i_qry_y - r_row);

    assign w_take = r_placed && r_ready && (!i_tok.found || (r_dist < i_tok.dsq));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_placed <= 1'b0;
            r_ready  <= 1'b0;
        end else begin
            if (i_cmd.place) begin
                r_placed <= 1'b1;
                r_ready  <= 1'b0;
            end else if (i_cmd.mark_on) begin
                r_ready  <= 1'b1;
            end else if (i_cmd.mark_off) begin
                r_ready  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.place) begin
            r_col <= i_pos_x;
            r_row <= i_pos_y;
        end
        r_sq_x <= {{POS_W{1'b0}}, w_dx} * {{POS_W{1'b0}}, w_dx};
        r_sq_y <= {{POS_W{1'b0}}, w_dy} * {{POS_W{1'b0}}, w_dy};
        r_dist <= {1'b0, r_sq_x} + {1'b0, r_sq_y};
        if (w_take) begin
            r_tok.found <= 1'b1;
            r_tok.dsq   <= r_dist;
            r_tok.idx   <= SITE_IDX_W'(CELL_IDX);
        end else begin
            r_tok <= i_tok;
        end
    end

    assign o_tok = r_tok;

endmodule
`default_nettype wire

[src/nearest_available_site_select.sv]
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// nearest_available_site_select
// Site table with place, mark and nearest-site query over a row of cells.
// ============================================================================
// Place, available and timeout requests: result valid the cycle after accept.
// Query: square, sum, then the running best hops one cell at a time down the
// row; the result loads once that pass ends and the output is free. No new
// request is taken until the query result has been loaded.
// Reset: all sites unplaced and unavailable, grid width and height 4096.
module nearest_available_site_select #(
    parameter int MAX_SITES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_kind,
    input  logic [nass_pkg::SITE_W-1:0]   i_site_index,
    input  logic [nass_pkg::POS_W-1:0]    i_pos_x,
    input  logic [nass_pkg::POS_W-1:0]    i_pos_y,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_found,
    output logic [nass_pkg::SITE_W-1:0]   o_best_site,
    output logic                          o_error
);
    import nass_pkg::*;

    localparam int CNT_W = $clog2(MAX_SITES + 2);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_SITES + 1);

    t_state            r_state;
    t_state            n_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [POS_W-1:0]  r_qry_x;
    logic [POS_W-1:0]  r_qry_y;
    logic              r_qry_err;
    logic [DIM_W-1:0]  r_grid_w;
    logic [DIM_W-1:0]  r_grid_h;
    logic              r_out_valid;
    logic              r_found;
    logic [SITE_W-1:0] r_best;
    logic              r_err;

    logic              w_cfg_wr;
    logic [DIM_W-1:0]  w_eff_w;
    logic [DIM_W-1:0]  w_eff_h;
    logic              w_inside;
    logic              w_site_ok;
    logic              w_is_query;
    logic              w_out_free;
    logic              w_in_ready;
    logic              w_accept;
    logic              w_load_imm;
    logic              w_load_qry;
    t_tok              w_tok [MAX_SITES+1];

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w <= GRID_RESET;
            r_grid_h <= GRID_RESET;
        end else if (w_cfg_wr) begin
            unique case (t_reg'(paddr[2]))
                REG_GRID_WIDTH:  r_grid_w <= pwdata[DIM_W-1:0];
                REG_GRID_HEIGHT: r_grid_h <= pwdata[DIM_W-1:0];
                default:         r_grid_w <= r_grid_w;
            endcase
        end
    end

    always_comb begin
        unique case (t_reg'(paddr[2]))
            REG_GRID_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, r_grid_w};
            REG_GRID_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, r_grid_h};
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Request decode
    // ------------------------------------------------------------------
    assign w_eff_w = (r_grid_w > DIM_W'(GRID_DIM_MAX)) ? DIM_W'(GRID_DIM_MAX) : r_grid_w;
    assign w_eff_h = (r_grid_h > DIM_W'(GRID_DIM_MAX)) ? DIM_W'(GRID_DIM_MAX) : r_grid_h;
    assign w_inside   = ({1'b0, i_pos_x} < w_eff_w) && ({1'b0, i_pos_y} < w_eff_h);
    assign w_site_ok  = ({3'b000, i_site_index} < 7'(MAX_SITES));
    assign w_is_query = (t_kind'(i_kind) == KIND_QUERY);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && w_in_ready;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && w_is_query) begin
                    n_state = w_inside ? ST_RUN : ST_DONE;
                end
            end
            ST_RUN: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_in_ready = 1'b0;
        w_load_qry = 1'b0;
        unique case (r_state)
            ST_IDLE: w_in_ready = w_is_query || w_out_free;
            ST_RUN:  w_in_ready = 1'b0;
            ST_DONE: w_load_qry = w_out_free;
            default: w_in_ready = 1'b0;
        endcase
    end

    assign w_load_imm = w_accept && !w_is_query;
    assign o_in_ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_RUN) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else begin
                r_cnt <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && w_is_query) begin
            r_qry_x   <= i_pos_x;
            r_qry_y   <= i_pos_y;
            r_qry_err <= !w_inside;
        end
    end

    // ------------------------------------------------------------------
    // Cell row
    // ------------------------------------------------------------------
    assign w_tok[0] = '0;

    for (genvar k = 0; k < MAX_SITES; k++) begin : g_cell
        t_cell_cmd w_cmd;
        logic      w_hit;

        assign w_hit = w_load_imm && w_site_ok && ({3'b000, i_site_index} == 7'(k));
        assign w_cmd.place    = w_hit && (t_kind'(i_kind) == KIND_PLACE) && w_inside;
        assign w_cmd.mark_on  = w_hit && (t_kind'(i_kind) == KIND_AVAIL);
        assign w_cmd.mark_off = w_hit && (t_kind'(i_kind) == KIND_TIMEOUT);

        nass_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_pos_x (i_pos_x),
            .i_pos_y (i_pos_y),
            .i_qry_x (r_qry_x),
            .i_qry_y (r_qry_y),
            .i_tok   (w_tok[k]),
            .o_tok   (w_tok[k+1])
        );
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_imm || w_load_qry) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_imm) begin
            r_found <= 1'b0;
            r_best  <= '0;
            r_err   <= (t_kind'(i_kind) == KIND_PLACE) && w_site_ok && !w_inside;
        end else if (w_load_qry) begin
            r_found <= !r_qry_err && w_tok[MAX_SITES].found;
            r_best  <= (!r_qry_err && w_tok[MAX_SITES].found) ?
                       w_tok[MAX_SITES].idx[SITE_W-1:0] : '0;
            r_err   <= r_qry_err;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_found     = r_found;
    assign o_best_site = r_best;
    assign o_error     = r_err;

`ifndef ASSERT_OFF
    a_found_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_found && o_error))
        else $error("found and error both set");

    a_best_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_best_site == '0))
        else $error("best site nonzero without a find");

    a_busy_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_in_ready)
        else $error("request taken while a query runs");

    a_imm_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && !w_is_query) |=> o_out_valid)
        else $error("no result after update request");
`endif

endmodule
`default_nettype wire
